/* src/alignment_fault_decoder_defines.svh */
// Assertion helpers shared by the decoder RTL.
`ifndef ALIGNMENT_FAULT_DECODER_DEFINES_SVH
`define ALIGNMENT_FAULT_DECODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("alignment fault decoder check failed");

// Next-cycle implication, checked out of reset.
`define AFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("alignment fault decoder check failed");

`endif

/* src/afd_pkg.sv */
`timescale 1ns / 1ps

package afd_pkg;

  localparam int unsigned LINE_BYTES_DEFAULT = 32;

  localparam logic [5:0] OPCODE_EXTENDED  = 6'd31;
  localparam logic [6:0] BLOCK_ZERO_CLASS = 7'h5F;

  typedef enum logic [1:0] {
    STATUS_HANDLED    = 2'd0,
    STATUS_BLOCK_ZERO = 2'd1,
    STATUS_UNHANDLED  = 2'd2
  } status_t;

  typedef struct packed {
    logic sxer;
    logic simm;
    logic sws;
    logic mult;
    logic upd;
    logic fp;
    logic se;
    logic st;
    logic ld;
  } attr_t;

  typedef struct packed {
    logic [3:0] len;
    attr_t      attr;
  } class_entry_t;

  localparam attr_t ATTR_LD   = '{ld:   1'b1, default: 1'b0};
  localparam attr_t ATTR_ST   = '{st:   1'b1, default: 1'b0};
  localparam attr_t ATTR_SE   = '{se:   1'b1, default: 1'b0};
  localparam attr_t ATTR_FP   = '{fp:   1'b1, default: 1'b0};
  localparam attr_t ATTR_UPD  = '{upd:  1'b1, default: 1'b0};
  localparam attr_t ATTR_MULT = '{mult: 1'b1, default: 1'b0};
  localparam attr_t ATTR_SWS  = '{sws:  1'b1, default: 1'b0};
  localparam attr_t ATTR_SIMM = '{simm: 1'b1, default: 1'b0};
  localparam attr_t ATTR_SXER = '{sxer: 1'b1, default: 1'b0};

  function automatic class_entry_t class_lookup(input logic [6:0] idx);
    class_entry_t e;
    e = '0;
    case (idx)
      7'h00, 7'h60: begin e.len = 4'd4; e.attr = ATTR_LD; end
      7'h02, 7'h62: begin e.len = 4'd4; e.attr = ATTR_ST; end
      7'h04, 7'h64: begin e.len = 4'd2; e.attr = ATTR_LD; end
      7'h05, 7'h65: begin e.len = 4'd2; e.attr = attr_t'(ATTR_LD | ATTR_SE); end
      7'h06, 7'h66: begin e.len = 4'd2; e.attr = ATTR_ST; end
      7'h07:        begin e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_MULT); end
      7'h08, 7'h68: begin
        e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_FP | ATTR_SWS);
      end
      7'h09, 7'h69: begin e.len = 4'd8; e.attr = attr_t'(ATTR_LD | ATTR_FP); end
      7'h0A, 7'h6A: begin
        e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_FP | ATTR_SWS);
      end
      7'h0B, 7'h6B: begin e.len = 4'd8; e.attr = attr_t'(ATTR_ST | ATTR_FP); end
      7'h10, 7'h70: begin e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_UPD); end
      7'h12, 7'h72: begin e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_UPD); end
      7'h14, 7'h74: begin e.len = 4'd2; e.attr = attr_t'(ATTR_LD | ATTR_UPD); end
      7'h15, 7'h75: begin
        e.len = 4'd2; e.attr = attr_t'(ATTR_LD | ATTR_SE | ATTR_UPD);
      end
      7'h16, 7'h76: begin e.len = 4'd2; e.attr = attr_t'(ATTR_ST | ATTR_UPD); end
      7'h17:        begin e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_MULT); end
      7'h18, 7'h78: begin
        e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_FP | ATTR_SWS | ATTR_UPD);
      end
      7'h19, 7'h79: begin
        e.len = 4'd8; e.attr = attr_t'(ATTR_LD | ATTR_FP | ATTR_UPD);
      end
      7'h1A, 7'h7A: begin
        e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_FP | ATTR_SWS | ATTR_UPD);
      end
      7'h1B, 7'h7B: begin
        e.len = 4'd8; e.attr = attr_t'(ATTR_ST | ATTR_FP | ATTR_UPD);
      end
      7'h28: begin e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_SXER); end
      7'h29: begin e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_SIMM); end
      7'h2A: begin e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_SXER); end
      7'h2B: begin e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_SIMM); end
      7'h48: begin e.len = 4'd4; e.attr = attr_t'(ATTR_LD | ATTR_SWS); end
      7'h4A: begin e.len = 4'd4; e.attr = attr_t'(ATTR_ST | ATTR_SWS); end
      7'h4C: begin e.len = 4'd2; e.attr = attr_t'(ATTR_LD | ATTR_SWS); end
      7'h4E: begin e.len = 4'd2; e.attr = attr_t'(ATTR_ST | ATTR_SWS); end
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

/* src/alignment_fault_decoder.sv */
`timescale 1ns / 1ps

// Alignment fault decoder. Takes one fault event per beat (instruction word, fault
// status, XER string count, fault address) and returns one decoded beat: operation
// attributes, element size, total bytes and register count for all handled forms,
// data and base registers, and a status in tuser (handled, cache block zero with the
// line-aligned address, or unhandled). A new beat is accepted every cycle while the
// output is not stalled; each beat passes through the input register and then through
// the table lookup and count logic into the result register. The decode source
// (instruction word or fault status) is selected by cfg_wr_data, written under
// cfg_wr_en; the user must write it only while no beat is in flight, which the block
// does not enforce. It resets to instruction. LINE_BYTES must be a power of two.

`include "alignment_fault_decoder_defines.svh"

module alignment_fault_decoder #(
  parameter int unsigned LINE_BYTES = afd_pkg::LINE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,     // decode_from_instruction

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] instruction_word, [48:32] fault_status, [55:49] xer_byte_count,
  // [87:56] fault_address
  input  logic [87:0] s_axis_tdata,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] is_store, [1] sign_extend, [2] is_float, [3] swap_or_single,
  // [4] update_base, [8:5] element_bytes, [16:9] total_bytes,
  // [22:17] register_count, [27:23] data_register, [32:28] base_register,
  // [64:33] line_base, [71:65] zero
  output logic [71:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  localparam logic [31:0] LineMask = ~(32'(LINE_BYTES) - 32'd1);

  logic        decode_from_instruction;

  logic        in_valid;
  logic [31:0] in_iw;
  logic [16:0] in_fs;
  logic [6:0]  in_xer;
  logic [31:0] in_addr;

  logic        out_valid;
  logic [71:0] out_data;
  logic [1:0]  out_status;

  logic        out_load;
  logic        in_load;

  logic [6:0]                 idx;
  logic [4:0]                 dreg;
  logic [4:0]                 breg;
  afd_pkg::class_entry_t      ent;
  afd_pkg::status_t           status_next;
  logic [3:0]                 elem;
  logic [7:0]                 total;
  logic [5:0]                 regs;
  logic [31:0]                line;
  logic [8:0]                 round_sum;
  logic [4:0]                 imm_cnt;
  afd_pkg::attr_t             attr;
  logic [71:0]                out_data_next;

  assign out_load      = !out_valid || m_axis_tready;
  assign in_load       = !in_valid || out_load;
  assign s_axis_tready = in_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_from_instruction <= 1'b1;
    end else if (cfg_wr_en) begin
      decode_from_instruction <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load && s_axis_tvalid) begin
      in_iw   <= s_axis_tdata[31:0];
      in_fs   <= s_axis_tdata[48:32];
      in_xer  <= s_axis_tdata[55:49];
      in_addr <= s_axis_tdata[87:56];
    end
  end

  always_comb begin
    if (decode_from_instruction) begin
      dreg = in_iw[25:21];
      breg = in_iw[20:16];
      if (in_iw[31:26] != afd_pkg::OPCODE_EXTENDED) begin
        idx = {2'b00, in_iw[26], in_iw[30:27]};
      end else begin
        idx = {in_iw[2:1], in_iw[6], in_iw[10:7]};
      end
    end else begin
      dreg = in_fs[9:5];
      breg = in_fs[4:0];
      idx  = in_fs[16:10];
    end
  end

  assign ent     = afd_pkg::class_lookup(idx);
  assign imm_cnt = in_iw[15:11];

  always_comb begin
    status_next = afd_pkg::STATUS_UNHANDLED;
    attr        = '0;
    elem        = 4'd0;
    total       = 8'd0;
    regs        = 6'd0;
    line        = 32'd0;
    round_sum   = 9'd0;
    if (ent.len == 4'd0) begin
      if (idx == afd_pkg::BLOCK_ZERO_CLASS) begin
        status_next = afd_pkg::STATUS_BLOCK_ZERO;
        line        = in_addr & LineMask;
      end
    end else begin
      status_next = afd_pkg::STATUS_HANDLED;
      attr        = ent.attr;
      elem        = ent.len;
      if (ent.attr.mult) begin
        regs  = 6'd32 - {1'b0, dreg};
        total = {4'd0, ent.len} * {2'd0, regs};
      end else if (ent.attr.simm || ent.attr.sxer) begin
        if (ent.attr.simm) begin
          total = (imm_cnt == 5'd0) ? 8'd32 : {3'd0, imm_cnt};
        end else begin
          total = {1'b0, in_xer};
        end
        round_sum = {1'b0, total} + 9'd3;
        regs      = round_sum[7:2];
      end else begin
        total = {4'd0, ent.len};
        regs  = 6'd1;
      end
    end
  end

  assign out_data_next = {7'd0, line, breg, dreg, regs, total, elem,
                          attr.upd, attr.sws, attr.fp, attr.se, attr.st};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_data   <= out_data_next;
      out_status <= status_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_status;

  `AFD_ASSERT_IMPL(a_unhandled_zero, clk, rst,
    m_axis_tvalid && (m_axis_tuser != afd_pkg::STATUS_HANDLED),
    m_axis_tdata[22:0] == 23'd0)
  `AFD_ASSERT_IMPL(a_handled_size, clk, rst,
    m_axis_tvalid && (m_axis_tuser == afd_pkg::STATUS_HANDLED),
    m_axis_tdata[8:5] != 4'd0)
  `AFD_ASSERT_IMPL(a_line_only_bz, clk, rst,
    m_axis_tvalid && (m_axis_tuser != afd_pkg::STATUS_BLOCK_ZERO),
    m_axis_tdata[64:33] == 32'd0)
  `AFD_ASSERT_NEXT(a_stall_keeps_input, clk, rst,
    in_valid && out_valid && !m_axis_tready,
    in_valid && out_valid)

endmodule

/* verif/alignment_fault_decoder_test.sv */
`timescale 1ns / 1ps

module alignment_fault_decoder_test;

  localparam int unsigned LINE_BYTES  = afd_pkg::LINE_BYTES_DEFAULT;
  localparam int          STALL_LIMIT = 1000;
  localparam int          SETTLE      = 4;
  localparam int          RAND_EVENTS = 285;

  typedef struct packed {
    logic [31:0] addr;
    logic [6:0]  xer;
    logic [16:0] fstat;
    logic [31:0] iword;
  } fault_event_t;

  typedef struct packed {
    afd_pkg::status_t status;
    logic        is_store;
    logic        sign_ext;
    logic        is_float;
    logic        swap_single;
    logic        update_base;
    logic [3:0]  elem_bytes;
    logic [7:0]  total_bytes;
    logic [5:0]  reg_count;
    logic [4:0]  data_reg;
    logic [4:0]  base_reg;
    logic [31:0] line_base;
  } decoded_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  logic        decode_src_instr = 1'b1;
  int          src_idle_pct;
  int          sink_idle_pct;
  int          errors;
  int          events_sent;
  int          beats_checked;
  int          n_handled, n_block_zero, n_unhandled;
  int          stall_cycles;
  decoded_t    pending_decodes[$];
  logic [6:0]  known_classes[$];

  alignment_fault_decoder #(
    .LINE_BYTES(LINE_BYTES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Upper quarter of the class space mirrors the lower one, bar the multiple forms.
  function automatic void lookup_class(input logic [6:0] idx, output logic [3:0] len,
                                       output afd_pkg::attr_t a);
    logic [6:0] key;
    key = idx;
    if (idx[6:5] == 2'b11 && idx[3:0] != 4'h7) key = {2'b00, idx[4:0]};
    len = 4'd0;
    a   = '0;
    case (key)
      7'h00: begin len = 4'd4; a.ld = 1'b1; end
      7'h02: begin len = 4'd4; a.st = 1'b1; end
      7'h04: begin len = 4'd2; a.ld = 1'b1; end
      7'h05: begin len = 4'd2; a.ld = 1'b1; a.se = 1'b1; end
      7'h06: begin len = 4'd2; a.st = 1'b1; end
      7'h07: begin len = 4'd4; a.ld = 1'b1; a.mult = 1'b1; end
      7'h08: begin len = 4'd4; a.ld = 1'b1; a.fp = 1'b1; a.sws = 1'b1; end
      7'h09: begin len = 4'd8; a.ld = 1'b1; a.fp = 1'b1; end
      7'h0A: begin len = 4'd4; a.st = 1'b1; a.fp = 1'b1; a.sws = 1'b1; end
      7'h0B: begin len = 4'd8; a.st = 1'b1; a.fp = 1'b1; end
      7'h10: begin len = 4'd4; a.ld = 1'b1; a.upd = 1'b1; end
      7'h12: begin len = 4'd4; a.st = 1'b1; a.upd = 1'b1; end
      7'h14: begin len = 4'd2; a.ld = 1'b1; a.upd = 1'b1; end
      7'h15: begin len = 4'd2; a.ld = 1'b1; a.se = 1'b1; a.upd = 1'b1; end
      7'h16: begin len = 4'd2; a.st = 1'b1; a.upd = 1'b1; end
      7'h17: begin len = 4'd4; a.st = 1'b1; a.mult = 1'b1; end
      7'h18: begin len = 4'd4; a.ld = 1'b1; a.fp = 1'b1; a.sws = 1'b1; a.upd = 1'b1; end
      7'h19: begin len = 4'd8; a.ld = 1'b1; a.fp = 1'b1; a.upd = 1'b1; end
      7'h1A: begin len = 4'd4; a.st = 1'b1; a.fp = 1'b1; a.sws = 1'b1; a.upd = 1'b1; end
      7'h1B: begin len = 4'd8; a.st = 1'b1; a.fp = 1'b1; a.upd = 1'b1; end
      7'h28: begin len = 4'd4; a.ld = 1'b1; a.sxer = 1'b1; end
      7'h29: begin len = 4'd4; a.ld = 1'b1; a.simm = 1'b1; end
      7'h2A: begin len = 4'd4; a.st = 1'b1; a.sxer = 1'b1; end
      7'h2B: begin len = 4'd4; a.st = 1'b1; a.simm = 1'b1; end
      7'h48: begin len = 4'd4; a.ld = 1'b1; a.sws = 1'b1; end
      7'h4A: begin len = 4'd4; a.st = 1'b1; a.sws = 1'b1; end
      7'h4C: begin len = 4'd2; a.ld = 1'b1; a.sws = 1'b1; end
      7'h4E: begin len = 4'd2; a.st = 1'b1; a.sws = 1'b1; end
      default: ;
    endcase
  endfunction

  function automatic decoded_t decode_fault(input fault_event_t ev, input logic from_instr);
    decoded_t       r;
    logic [6:0]     idx;
    logic [3:0]     len;
    afd_pkg::attr_t a;
    int unsigned    nbytes, nregs;
    r        = '0;
    r.status = afd_pkg::STATUS_UNHANDLED;
    if (from_instr) begin
      r.data_reg = ev.iword[25:21];
      r.base_reg = ev.iword[20:16];
      if (ev.iword[31:26] != afd_pkg::OPCODE_EXTENDED)
        idx = {2'b00, ev.iword[26], ev.iword[30:27]};
      else idx = {ev.iword[2:1], ev.iword[6], ev.iword[10:7]};
    end else begin
      idx        = ev.fstat[16:10];
      r.data_reg = ev.fstat[9:5];
      r.base_reg = ev.fstat[4:0];
    end
    lookup_class(idx, len, a);
    if (len == 4'd0) begin
      if (idx == afd_pkg::BLOCK_ZERO_CLASS) begin
        r.status    = afd_pkg::STATUS_BLOCK_ZERO;
        r.line_base = ev.addr & ~(32'(LINE_BYTES) - 32'd1);
      end
    end else begin
      r.status      = afd_pkg::STATUS_HANDLED;
      r.is_store    = a.st;
      r.sign_ext    = a.se;
      r.is_float    = a.fp;
      r.swap_single = a.sws;
      r.update_base = a.upd;
      r.elem_bytes  = len;
      if (a.mult) begin
        nregs  = 32 - r.data_reg;
        nbytes = len * nregs;
      end else if (a.simm || a.sxer) begin
        if (a.simm) nbytes = (ev.iword[15:11] == 5'd0) ? 32 : ev.iword[15:11];
        else nbytes = ev.xer;
        nregs = (nbytes + 3) / 4;
      end else begin
        nbytes = len;
        nregs  = 1;
      end
      r.total_bytes = nbytes[7:0];
      r.reg_count   = nregs[5:0];
    end
    return r;
  endfunction

  // Primary-opcode encoding only reaches the low quarter; filler[1] picks it there.
  function automatic logic [31:0] instr_for_class(input logic [6:0] idx, input logic [4:0] rd,
                                                  input logic [4:0] ra, input logic [4:0] nb,
                                                  input logic [31:0] filler);
    logic [31:0] w;
    w = filler;
    if (idx[6:5] == 2'b00 && filler[1]) begin
      w[30:27] = idx[3:0];
      w[26]    = idx[4];
      if (w[31:26] == afd_pkg::OPCODE_EXTENDED) w[31] = 1'b1;
    end else begin
      w[31:26] = afd_pkg::OPCODE_EXTENDED;
      w[2:1]   = idx[6:5];
      w[6]     = idx[4];
      w[10:7]  = idx[3:0];
    end
    w[25:21] = rd;
    w[20:16] = ra;
    w[15:11] = nb;
    return w;
  endfunction

  function automatic fault_event_t mk_event(input logic [31:0] iw, input logic [16:0] fs,
                                            input logic [6:0] xer, input logic [31:0] addr);
    fault_event_t ev;
    ev.iword = iw;
    ev.fstat = fs;
    ev.xer   = xer;
    ev.addr  = addr;
    return ev;
  endfunction

  // Entered and left at a falling edge.
  task automatic send_event(input fault_event_t ev);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ev;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_decodes.push_back(decode_fault(ev, decode_src_instr));
    events_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_decode_source(input logic from_instr);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= from_instr;
    @(negedge clk);
    cfg_wr_en        <= 1'b0;
    decode_src_instr = from_instr;
  endtask

  task automatic test_instruction_decode();
    send_event(mk_event(32'h0, 17'h0, 7'h0, 32'h0));
    send_event(mk_event('1, '1, '1, '1));
    send_event(mk_event(instr_for_class(afd_pkg::BLOCK_ZERO_CLASS, 5'd31, 5'd0, 5'd0, 32'h0),
                        17'h0, 7'h0, 32'hFFFF_FFFF));
    send_event(mk_event(instr_for_class(afd_pkg::BLOCK_ZERO_CLASS, 5'd0, 5'd31, 5'd31, '1),
                        '1, '1, 32'h0000_001F));
    send_event(mk_event(instr_for_class(7'h07, 5'd0, 5'd1, 5'd0, 32'h2), 17'h0, 7'h0, 32'h3));
    send_event(mk_event(instr_for_class(7'h07, 5'd31, 5'd2, 5'd0, 32'h0), 17'h0, 7'h0, 32'h5));
    send_event(mk_event(instr_for_class(7'h17, 5'd0, 5'd3, 5'd0, 32'h2), 17'h0, 7'h0, 32'h7));
    send_event(mk_event(instr_for_class(7'h29, 5'd4, 5'd5, 5'd0, 32'h0), 17'h0, 7'h0, 32'h1));
    send_event(mk_event(instr_for_class(7'h29, 5'd6, 5'd7, 5'd31, '1), '1, '1, 32'h2));
    send_event(mk_event(instr_for_class(7'h2B, 5'd8, 5'd9, 5'd1, 32'h0), 17'h0, 7'h0, 32'h9));
    send_event(mk_event(instr_for_class(7'h28, 5'd10, 5'd11, 5'd3, 32'h0), 17'h0, 7'h0, 32'h6));
    send_event(mk_event(instr_for_class(7'h28, 5'd12, 5'd13, 5'd3, 32'h0), 17'h0, 7'h7F,
                        32'hA));
    send_event(mk_event(instr_for_class(7'h2A, 5'd14, 5'd15, 5'd0, 32'h0), 17'h0, 7'h1,
                        32'hB));
    send_event(mk_event(instr_for_class(7'h05, 5'd16, 5'd17, 5'd0, 32'h2), 17'h0, 7'h0, 32'h1));
    send_event(mk_event(instr_for_class(7'h09, 5'd18, 5'd19, 5'd0, 32'h0), 17'h0, 7'h0, 32'h3));
    send_event(mk_event(instr_for_class(7'h18, 5'd20, 5'd21, 5'd0, 32'h2), 17'h0, 7'h0, 32'h2));
    send_event(mk_event(instr_for_class(7'h4E, 5'd22, 5'd23, 5'd0, '1), 17'h0, 7'h0, 32'h1));
    send_event(mk_event(instr_for_class(7'h7B, 5'd24, 5'd25, 5'd0, '1), '1, '1, 32'h4));
    send_event(mk_event(instr_for_class(7'h7F, 5'd26, 5'd27, 5'd0, '1), '1, '1, 32'hFFFF_FFE1));
  endtask

  task automatic test_status_decode();
    send_event(mk_event('1, 17'h0, 7'h0, 32'h0));
    send_event(mk_event(32'h0, '1, '1, '1));
    send_event(mk_event(32'h0, {afd_pkg::BLOCK_ZERO_CLASS, 5'd7, 5'd9}, 7'h0, 32'h1234_5678));
    send_event(mk_event(32'h0, {7'h07, 5'd0, 5'd31}, 7'h0, 32'h1));
    send_event(mk_event(32'h0, {7'h28, 5'd3, 5'd4}, 7'h7F, 32'h2));
    send_event(mk_event(32'h0, {7'h29, 5'd5, 5'd6}, 7'h0, 32'h3));
  endtask

  // Mostly events of a known class with random content, the rest noise.
  task automatic test_random_events(input int count);
    fault_event_t ev;
    logic [6:0]   idx;
    repeat (count) begin
      if ($urandom_range(99) < 70)
        idx = known_classes[$urandom_range(known_classes.size() - 1)];
      else idx = 7'($urandom_range(127));
      ev = mk_event($urandom, 17'($urandom), 7'($urandom_range(127)), $urandom);
      if ($urandom_range(7) == 0) ev.xer = 7'h0;
      if ($urandom_range(99) < 80) begin
        if (decode_src_instr)
          ev.iword = instr_for_class(idx, 5'($urandom_range(31)), 5'($urandom_range(31)),
                                     5'($urandom_range(31)), $urandom);
        else ev.fstat[16:10] = idx;
      end
      send_event(ev);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on beat %0d: %s got 0x%0h, expected 0x%0h", beats_checked, what, got,
             want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);

  always @(posedge clk) begin : check_results
    decoded_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_decodes.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[63:0], 64'h0);
      end else begin
        want = pending_decodes.pop_front();
        check_field("status", 64'(m_axis_tuser), 64'(want.status));
        check_field("is_store", 64'(m_axis_tdata[0]), 64'(want.is_store));
        check_field("sign_extend", 64'(m_axis_tdata[1]), 64'(want.sign_ext));
        check_field("is_float", 64'(m_axis_tdata[2]), 64'(want.is_float));
        check_field("swap_or_single", 64'(m_axis_tdata[3]), 64'(want.swap_single));
        check_field("update_base", 64'(m_axis_tdata[4]), 64'(want.update_base));
        check_field("element_bytes", 64'(m_axis_tdata[8:5]), 64'(want.elem_bytes));
        check_field("total_bytes", 64'(m_axis_tdata[16:9]), 64'(want.total_bytes));
        check_field("register_count", 64'(m_axis_tdata[22:17]), 64'(want.reg_count));
        check_field("data_register", 64'(m_axis_tdata[27:23]), 64'(want.data_reg));
        check_field("base_register", 64'(m_axis_tdata[32:28]), 64'(want.base_reg));
        check_field("line_base", 64'(m_axis_tdata[64:33]), 64'(want.line_base));
        check_field("padding", 64'(m_axis_tdata[71:65]), 64'h0);
        case (want.status)
          afd_pkg::STATUS_HANDLED:    n_handled++;
          afd_pkg::STATUS_BLOCK_ZERO: n_block_zero++;
          default:                    n_unhandled++;
        endcase
      end
      beats_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [3:0]     len;
    afd_pkg::attr_t a;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    src_idle_pct  = 28;
    sink_idle_pct = 53;
    for (int i = 0; i < 128; i++) begin
      lookup_class(7'(i), len, a);
      if (len != 4'd0 || 7'(i) == afd_pkg::BLOCK_ZERO_CLASS) known_classes.push_back(7'(i));
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_instruction_decode();
    set_decode_source(1'b0);
    test_status_decode();
    for (int phase = 0; phase < 3; phase++) begin
      src_idle_pct  = (phase == 0) ? 28 : (phase == 1) ? 53 : 0;
      sink_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 28 : 0;
      set_decode_source(1'b1);
      test_random_events(RAND_EVENTS);
      set_decode_source(1'b0);
      test_random_events(RAND_EVENTS);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    $display("Decoded %0d fault events from both sources under three back-pressure mixes:",
             events_sent);
    $display("  %0d handled, %0d block zero, %0d unhandled, %0d mismatches", n_handled,
             n_block_zero, n_unhandled, errors);
    if (errors == 0 && pending_decodes.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

/* alignment_fault_decoder.f */
+incdir+src
src/afd_pkg.sv
src/alignment_fault_decoder.sv
verif/alignment_fault_decoder_test.sv
